FILE: src/pwkd_pkg.sv
package pwkd_pkg;

	localparam int SYNC_SAMPLES = 10;
	localparam int KEY_BYTES = 4;

	localparam int DUR_W = 16;
	localparam int SUM_W = 21;
	localparam int PERIOD_W = 17;
	localparam int KEY_W = 32;
	localparam int CNT_W = 8;
	localparam int SAMPLE_W = 4;
	localparam int BYTES_W = 3;
	localparam int LIMIT_W = 8;

	localparam logic [LIMIT_W-1:0] START_LIMIT_RESET = 8'd40;
	// start word and stop word share the same pattern
	localparam logic [CNT_W-1:0] FRAME_WORD = 8'b0000_0010;
	localparam logic [CNT_W-1:0] FRAME_BITS = 8'd3;
	localparam logic [CNT_W-1:0] BYTE_BITS = 8'd8;

	// divide by SYNC_SAMPLES as multiply by a rounded-up reciprocal
	localparam int SYNC_DIV_SHIFT = 26;
	localparam logic [SYNC_DIV_SHIFT:0] SYNC_RECIP =
		(SYNC_DIV_SHIFT+1)'(((1 << SYNC_DIV_SHIFT) + SYNC_SAMPLES - 1) / SYNC_SAMPLES);

	typedef enum logic [2:0] {
		PH_SYNC,
		PH_START_BIT,
		PH_START_WORD,
		PH_READ,
		PH_STOP_WORD
	} pwkd_phase_t;

	typedef struct packed {
		logic req_type;
		logic level;
		logic [DUR_W-1:0] duration;
	} pwkd_item_t;

endpackage

FILE: src/pwkd_period_div.sv
module pwkd_period_div
	import pwkd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic [SUM_W-1:0] period_sum,
	output logic [PERIOD_W-1:0] bit_period
);

	localparam int PROD_W = SUM_W + SYNC_DIV_SHIFT + 1;

	logic [PROD_W-1:0] prod;
	logic [PERIOD_W-1:0] bit_period_q;

	assign prod = {{(SYNC_DIV_SHIFT+1){1'b0}}, period_sum} * {{SUM_W{1'b0}}, SYNC_RECIP};

	// the sum is frozen once sync ends, so the registered quotient settles in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= '0;
		end else begin
			bit_period_q <= prod[SYNC_DIV_SHIFT +: PERIOD_W];
		end
	end

	assign bit_period = bit_period_q;

endmodule

FILE: src/pwkd_core.sv
module pwkd_core
	import pwkd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic step,
	input pwkd_item_t item,
	input logic [LIMIT_W-1:0] start_bit_limit,
	output logic key_ready,
	output logic [KEY_W-1:0] key_value
);

	pwkd_phase_t phase_q, phase_n;
	logic edge_q, edge_n;
	logic [DUR_W-1:0] held_q, held_n;
	logic [SAMPLE_W-1:0] sample_q, sample_n;
	logic [SUM_W-1:0] sum_q, sum_n;
	logic [CNT_W-1:0] shift_q, shift_n;
	logic [CNT_W-1:0] bcnt_q, bcnt_n;
	logic [KEY_W-1:0] key_q, key_n;
	logic [BYTES_W-1:0] bytes_q, bytes_n;
	logic done_q, done_n;

	logic [PERIOD_W-1:0] bit_period;
	logic bit_event;
	logic clear;
	logic bit_val;
	logic long_high;
	logic [CNT_W-1:0] shifted;
	logic [CNT_W-1:0] bcnt_inc;
	logic [CNT_W:0] hunt_n;
	logic [SAMPLE_W:0] sample_inc;
	logic [BYTES_W-1:0] bytes_inc;

	pwkd_period_div u_div (
		.clk (clk),
		.arst_n (arst_n),
		.period_sum (sum_q),
		.bit_period (bit_period)
	);

	// low time of the bit is the last high pulse, high time is this low pulse
	assign bit_val = held_q >= bit_period[PERIOD_W-1:1];
	assign long_high = {1'b0, item.duration} > bit_period;
	assign shifted = {shift_q[CNT_W-2:0], bit_val};
	assign bcnt_inc = bcnt_q + 1'b1;
	assign hunt_n = {1'b0, bcnt_q} + 1'b1;
	assign sample_inc = {1'b0, sample_q} + 1'b1;
	assign bytes_inc = bytes_q + 1'b1;

	always_comb begin
		phase_n = phase_q;
		edge_n = edge_q;
		held_n = held_q;
		sample_n = sample_q;
		sum_n = sum_q;
		shift_n = shift_q;
		bcnt_n = bcnt_q;
		key_n = key_q;
		bytes_n = bytes_q;
		done_n = done_q;
		bit_event = 1'b0;
		clear = 1'b0;

		if (item.req_type) begin
			clear = 1'b1;
		end else if (!done_q) begin
			if (!edge_q) begin
				if (!item.level) begin
					edge_n = 1'b1;
					bit_event = 1'b1;
				end
			end else if (item.level) begin
				held_n = item.duration;
				edge_n = 1'b0;
			end
		end

		if (bit_event) begin
			unique case (phase_q)
				PH_SYNC: begin
					sum_n = sum_q + SUM_W'(item.duration) + SUM_W'(held_q);
					if (sample_inc >= (SAMPLE_W+1)'(SYNC_SAMPLES)) begin
						sample_n = '0;
						phase_n = PH_START_BIT;
					end else begin
						sample_n = sample_inc[SAMPLE_W-1:0];
					end
				end
				PH_START_BIT: begin
					if (long_high) begin
						bcnt_n = '0;
						phase_n = PH_START_WORD;
					end else if (hunt_n > {1'b0, start_bit_limit}) begin
						clear = 1'b1;
					end else begin
						bcnt_n = hunt_n[CNT_W-1:0];
					end
				end
				PH_START_WORD, PH_STOP_WORD: begin
					shift_n = shifted;
					bcnt_n = bcnt_inc;
					if (bcnt_inc == FRAME_BITS) begin
						if (shifted != FRAME_WORD) begin
							clear = 1'b1;
						end else if (phase_q == PH_START_WORD) begin
							bcnt_n = '0;
							shift_n = '0;
							phase_n = PH_READ;
						end else begin
							done_n = 1'b1;
						end
					end
				end
				PH_READ: begin
					shift_n = shifted;
					bcnt_n = bcnt_inc;
					if (bcnt_inc == BYTE_BITS) begin
						if (^shifted) begin
							clear = 1'b1;
						end else begin
							key_n = {key_q[KEY_W-CNT_W-1:0], shifted};
							bytes_n = bytes_inc;
							shift_n = '0;
							bcnt_n = '0;
							if (bytes_inc == BYTES_W'(KEY_BYTES)) begin
								// last bit of the key doubles as the stop bit
								if (long_high) begin
									phase_n = PH_STOP_WORD;
								end else begin
									clear = 1'b1;
								end
							end
						end
					end
				end
				default: begin
					clear = 1'b1;
				end
			endcase
		end

		if (clear) begin
			phase_n = PH_SYNC;
			edge_n = 1'b0;
			held_n = '0;
			sample_n = '0;
			sum_n = '0;
			shift_n = '0;
			bcnt_n = '0;
			key_n = '0;
			bytes_n = '0;
			done_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
		end else if (step) begin
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= 1'b0;
			held_q <= '0;
			sample_q <= '0;
			sum_q <= '0;
			shift_q <= '0;
			bcnt_q <= '0;
			key_q <= '0;
			bytes_q <= '0;
			done_q <= 1'b0;
		end else if (step) begin
			edge_q <= edge_n;
			held_q <= held_n;
			sample_q <= sample_n;
			sum_q <= sum_n;
			shift_q <= shift_n;
			bcnt_q <= bcnt_n;
			key_q <= key_n;
			bytes_q <= bytes_n;
			done_q <= done_n;
		end
	end

	assign key_ready = done_q;
	assign key_value = key_q;

endmodule

FILE: src/pulse_width_key_decoder.sv
// Pulse-width key decoder: one request per line pulse (level and duration) or a restart
// request, one result per request (key_ready and key_value). Requests are taken at one per
// cycle while results are taken; a request waits in the input register until it advances,
// and its result is then registered and held until taken, while one more request may wait
// in the input register. The bit period, the sum of the sync periods times a reciprocal, is
// registered in the cycle after sync ends, which the pulse alternation always leaves time for.
// start_bit_limit may be written through the cfg port at any idle moment; it resets to 40.
module pulse_width_key_decoder
	import pwkd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic req_type,
	input logic level,
	input logic [DUR_W-1:0] duration,
	output logic out_valid,
	input logic out_ready,
	output logic key_ready,
	output logic [KEY_W-1:0] key_value,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [LIMIT_W-1:0] cfg_data
);

	logic s1_valid_q;
	pwkd_item_t item_s1;
	logic out_valid_q;
	logic advance;
	logic [LIMIT_W-1:0] limit_q;

	assign advance = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{req_type: req_type, level: level, duration: duration};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= START_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// decoder state doubles as the result register
	pwkd_core u_core (
		.clk (clk),
		.arst_n (arst_n),
		.step (advance),
		.item (item_s1),
		.start_bit_limit (limit_q),
		.key_ready (key_ready),
		.key_value (key_value)
	);

	assign out_valid = out_valid_q;

endmodule

FILE: sim/tb_pulse_width_key_decoder.sv
module tb_pulse_width_key_decoder;
	import pwkd_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_REQUESTS = 70;

	typedef struct packed {
		logic rdy;
		logic [KEY_W-1:0] key;
	} key_result_t;

	typedef struct packed {
		logic fixed;
		key_result_t val;
	} row_note_t;

	typedef struct packed {
		logic rq;
		logic lv;
		logic [DUR_W-1:0] d;
		logic fixed;
		logic rdy;
		logic [KEY_W-1:0] key;
	} dir_row_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_LONG_HUNT,
		FLAW_START_WORD,
		FLAW_PARITY,
		FLAW_NO_STOP_BIT,
		FLAW_STOP_WORD
	} frame_flaw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic level = 1'b0;
	logic [DUR_W-1:0] duration = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic key_ready;
	logic [KEY_W-1:0] key_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	// line sequence: mostly sync-period samples with typed results, last few via the model
	dir_row_t dir_rows [0:24] = '{
		'{1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'hFFFF, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 32'h0},
		'{1'b1, 1'b0, 16'h0000, 1'b1, 1'b0, 32'h0},
		'{1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'h0001, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'h8000, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'h7FFF, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'h5555, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'hAAAA, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'h00FF, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'hFF00, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'h0F0F, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'hF0F0, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'h3333, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'hCCCC, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'h0002, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'h0003, 1'b1, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0, 32'h0},
		'{1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 32'h0},
		'{1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 32'h0}
	};

	// decoder tracking state
	pwkd_phase_t trk_phase;
	logic trk_rise;
	logic [DUR_W-1:0] trk_low;
	logic [SAMPLE_W-1:0] trk_samples;
	logic [SUM_W-1:0] trk_sum;
	logic [PERIOD_W-1:0] trk_period;
	logic [CNT_W-1:0] trk_bits;
	logic [CNT_W-1:0] trk_nbits;
	logic [KEY_W-1:0] trk_key;
	logic [BYTES_W-1:0] trk_nbytes;
	logic trk_done;
	logic [LIMIT_W-1:0] trk_limit;

	key_result_t pending_keys [$];
	row_note_t row_notes [$];

	int fail_count = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int restarts_seen = 0;
	int keys_decoded = 0;
	int quiet_cycles = 0;
	logic was_ready = 1'b0;
	bit send_busy = 1'b1;
	bit recv_busy = 1'b1;
	bit hold_req = 1'b0;
	int unsigned gen_bp;
	int unsigned cur_limit = START_LIMIT_RESET;

	pulse_width_key_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.level(level),
		.duration(duration),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.key_ready(key_ready),
		.key_value(key_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void trk_clear();
		trk_phase = PH_SYNC;
		trk_rise = 1'b0;
		trk_low = '0;
		trk_samples = '0;
		trk_sum = '0;
		trk_period = '0;
		trk_bits = '0;
		trk_nbits = '0;
		trk_key = '0;
		trk_nbytes = '0;
		trk_done = 1'b0;
	endfunction

	// one bit closed by a low pulse: hi is its high time, lo the held low time
	function automatic void trk_bit(input logic [DUR_W-1:0] hi, input logic [DUR_W-1:0] lo);
		logic rd;
		int unsigned n;
		rd = ({1'b0, lo} >= (trk_period >> 1));
		case (trk_phase)
			PH_SYNC: begin
				trk_sum = trk_sum + hi + lo;
				if (trk_samples + 1 >= SYNC_SAMPLES) begin
					trk_samples = '0;
					trk_period = PERIOD_W'(trk_sum / SYNC_SAMPLES);
					trk_phase = PH_START_BIT;
				end else begin
					trk_samples = trk_samples + 1'b1;
				end
			end
			PH_START_BIT: begin
				n = trk_nbits + 1;
				if (hi > trk_period) begin
					trk_nbits = '0;
					trk_phase = PH_START_WORD;
				end else if (n > trk_limit) begin
					trk_clear();
				end else begin
					trk_nbits = CNT_W'(n);
				end
			end
			PH_START_WORD, PH_STOP_WORD: begin
				trk_bits = {trk_bits[CNT_W-2:0], rd};
				trk_nbits = trk_nbits + 1'b1;
				if (trk_nbits == FRAME_BITS) begin
					if (trk_bits != FRAME_WORD) begin
						trk_clear();
					end else if (trk_phase == PH_START_WORD) begin
						trk_nbits = '0;
						trk_bits = '0;
						trk_phase = PH_READ;
					end else begin
						trk_done = 1'b1;
					end
				end
			end
			PH_READ: begin
				trk_bits = {trk_bits[CNT_W-2:0], rd};
				trk_nbits = trk_nbits + 1'b1;
				if (trk_nbits == BYTE_BITS) begin
					if (^trk_bits) begin
						trk_clear();
					end else begin
						trk_key = {trk_key[KEY_W-9:0], trk_bits};
						trk_nbytes = trk_nbytes + 1'b1;
						trk_bits = '0;
						trk_nbits = '0;
						if (trk_nbytes == KEY_BYTES) begin
							if (hi > trk_period)
								trk_phase = PH_STOP_WORD;
							else
								trk_clear();
						end
					end
				end
			end
			default: trk_clear();
		endcase
	endfunction

	function automatic key_result_t trk_step(input logic rq, input logic lv,
			input logic [DUR_W-1:0] d);
		key_result_t r;
		if (rq) begin
			trk_clear();
		end else if (!trk_done) begin
			if (!trk_rise) begin
				if (!lv) begin
					// set before the bit, a failure inside clears it again
					trk_rise = 1'b1;
					trk_bit(d, trk_low);
				end
			end else if (lv) begin
				trk_low = d;
				trk_rise = 1'b0;
			end
		end
		r.rdy = trk_done;
		r.key = trk_key;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch on %s at result %0d: expected %h, got %h",
				what, results_seen, want, got);
	endtask

	always @(posedge clk) begin : scoreboard
		key_result_t want;
		row_note_t note;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = trk_step(req_type, level, duration);
				note = row_notes.pop_front();
				if (note.fixed)
					want = note.val;
				if (req_type)
					restarts_seen++;
				if (want.rdy && !was_ready)
					keys_decoded++;
				was_ready = want.rdy;
				pending_keys.push_back(want);
			end
			if (cfg_valid && cfg_ready)
				trk_limit = cfg_data;
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_keys.size() == 0) begin
					report_mismatch("unexpected result", '0, key_value);
				end else begin
					want = pending_keys.pop_front();
					if (key_ready !== want.rdy)
						report_mismatch("key_ready", KEY_W'(want.rdy), KEY_W'(key_ready));
					if (key_value !== want.key)
						report_mismatch("key_value", want.key, key_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
			$display("tb_pulse_width_key_decoder: done, errors");
			$finish;
		end
	end

	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				// long hold-off so the decoder fills and backs up its input
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = recv_busy ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_request(input logic rq, input logic lv, input logic [DUR_W-1:0] d,
			input logic fixed = 1'b0, input key_result_t fixed_val = '0);
		int gap;
		gap = send_busy ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type = rq;
		level = lv;
		duration = d;
		row_notes.push_back({fixed, fixed_val});
		in_valid = 1'b1;
		requests_sent++;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid = 1'b0;
		while (pending_keys.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input int unsigned v);
		drain_results();
		cfg_data = LIMIT_W'(v);
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cur_limit = v;
	endtask

	task automatic send_bit(input int unsigned hi, input int unsigned lo);
		push_request(1'b0, 1'b1, DUR_W'(lo));
		push_request(1'b0, 1'b0, DUR_W'(hi));
	endtask

	function automatic int unsigned long_high();
		int unsigned x;
		x = gen_bp + 1 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2000));
		return (x > 65535) ? 65535 : x;
	endfunction

	// low time around the half-period threshold, the exact boundary now and then
	function automatic int unsigned pick_low(input logic b);
		int unsigned half;
		half = gen_bp / 2;
		if (b)
			return ($urandom_range(0, 3) == 0) ? half : $urandom_range(half, gen_bp);
		return ($urandom_range(0, 3) == 0) ? half - 1 : $urandom_range(0, half - 1);
	endfunction

	task automatic send_data_bit(input logic b, input bit long_hi);
		send_bit(long_hi ? long_high() : $urandom_range(0, gen_bp), pick_low(b));
	endtask

	task automatic send_frame(input frame_flaw_t flaw_in);
		frame_flaw_t flaw;
		int unsigned p, h, lo, sum, hunt, bad_byte, flip;
		int sel;
		logic [7:0] octet;
		logic [2:0] word;
		flaw = flaw_in;
		if (flaw == FLAW_LONG_HUNT && cur_limit > 40)
			flaw = FLAW_NONE;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			p = $urandom_range(4, 40);
		else if (sel == 1)
			p = $urandom_range(3000, 30000);
		else
			p = $urandom_range(40, 3000);
		push_request(1'b1, 1'($urandom_range(0, 1)), DUR_W'($urandom_range(0, 65535)));
		// first sync bit closes against a cleared low time
		h = $urandom_range(1, p - 1);
		push_request(1'b0, 1'b0, DUR_W'(h));
		sum = h;
		repeat (SYNC_SAMPLES - 1) begin
			h = $urandom_range(1, p - 1);
			lo = p - h + $urandom_range(0, 2);
			sum += h + lo;
			send_bit(h, lo);
		end
		gen_bp = sum / SYNC_SAMPLES;
		if (flaw == FLAW_LONG_HUNT)
			hunt = cur_limit + 1;
		else if (cur_limit <= 40 && $urandom_range(0, 7) == 0)
			hunt = cur_limit;
		else
			hunt = $urandom_range(0, (cur_limit < 12) ? cur_limit : 12);
		repeat (hunt) send_bit($urandom_range(0, gen_bp), $urandom_range(0, 65535));
		send_bit(long_high(), $urandom_range(0, 65535));
		word = FRAME_WORD[2:0];
		if (flaw == FLAW_START_WORD)
			word[$urandom_range(0, 2)] ^= 1'b1;
		for (int i = 2; i >= 0; i--)
			send_data_bit(word[i], 1'b0);
		bad_byte = $urandom_range(0, KEY_BYTES - 1);
		for (int n = 0; n < KEY_BYTES; n++) begin
			octet = 8'($urandom_range(0, 255));
			if (^octet)
				octet[0] = ~octet[0];
			if (flaw == FLAW_PARITY && n == bad_byte) begin
				flip = $urandom_range(0, 7);
				octet[flip] = ~octet[flip];
			end
			for (int i = 7; i >= 0; i--)
				send_data_bit(octet[i],
					n == KEY_BYTES - 1 && i == 0 && flaw != FLAW_NO_STOP_BIT);
		end
		word = FRAME_WORD[2:0];
		if (flaw == FLAW_STOP_WORD)
			word[$urandom_range(0, 2)] ^= 1'b1;
		for (int i = 2; i >= 0; i--)
			send_data_bit(word[i], 1'b0);
		// trailing pulses, ignored once the key is held
		repeat ($urandom_range(0, 3))
			push_request(1'b0, 1'($urandom_range(0, 1)), DUR_W'($urandom_range(0, 65535)));
	endtask

	task automatic send_noise(input int count);
		logic [DUR_W-1:0] d;
		repeat (count) begin
			case ($urandom_range(0, 3))
				0: d = '0;
				1: d = '1;
				default: d = DUR_W'($urandom_range(0, 65535));
			endcase
			push_request($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)), d);
		end
	endtask

	initial begin
		int target;
		int r;
		trk_limit = START_LIMIT_RESET;
		trk_clear();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			push_request(dir_rows[i].rq, dir_rows[i].lv, dir_rows[i].d, dir_rows[i].fixed,
				{dir_rows[i].rdy, dir_rows[i].key});

		for (int f = FLAW_NONE; f <= FLAW_STOP_WORD; f++)
			send_frame(frame_flaw_t'(f));

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				1: write_limit(0);
				2: write_limit(255);
				3: write_limit(1);
				4, 5: write_limit($urandom_range(2, 254));
				6: write_limit(START_LIMIT_RESET);
				default: ;
			endcase
			send_busy = (ph % 3 != 1);
			recv_busy = (ph % 3 != 2);
			if (ph == 2)
				hold_req = 1'b1;
			target = requests_sent + PHASE_REQUESTS;
			while (requests_sent < target) begin
				r = $urandom_range(0, 9);
				if (r < 4)
					send_frame(FLAW_NONE);
				else if (r < 7)
					send_frame(frame_flaw_t'($urandom_range(FLAW_LONG_HUNT, FLAW_STOP_WORD)));
				else
					send_noise($urandom_range(4, 16));
			end
		end

		in_valid = 1'b0;
		while (pending_keys.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		fail_count += pending_keys.size();
		$display("covered %0d requests (%0d restarts), %0d results, %0d keys decoded",
			requests_sent, restarts_seen, results_seen, keys_decoded);
		$display("start-bit limits 40, 0, 255, 1 and random, clean and damaged frames, noise");
		if (fail_count == 0)
			$display("tb_pulse_width_key_decoder: done, clean");
		else
			$display("tb_pulse_width_key_decoder: done, errors");
		$finish;
	end

endmodule
